>>> hw/rtl/pfus_pkg.sv
package pfus_pkg;

	localparam int BYTE_BITS      = 8;
	localparam int ACC_BITS       = 40;
	localparam int HELD_BITS      = 6;
	localparam int MAX_RESULTS    = 8;
	localparam int CNT_BITS       = 4;
	localparam int BPV_BITS       = 6;
	localparam int BSCALE_BITS    = 7;
	localparam int REF_BITS       = 48;
	localparam int RECIP_BITS     = 32;
	localparam int RAW_BITS       = 32;
	localparam int OUT_BITS       = 48;
	localparam int SUM_BITS       = 128;
	localparam int MAG_BITS       = 97;
	localparam int LIMB_BITS      = 32;
	localparam int MUL_STEPS      = 3;
	localparam int STEP_BITS      = 2;
	localparam int CFG_IDX_BITS   = 8;
	localparam int CFG_DATA_BITS  = 48;

	localparam int VALUE_BITS_MAX_DEF = 32;
	localparam int FRAC_BITS_DEF      = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_BITS_PER_VALUE     = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BINARY_SCALE       = 8'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_REFERENCE_VALUE    = 8'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DECIMAL_RECIPROCAL = 8'd3;

	localparam logic [BPV_BITS-1:0] BPV_RESET = 6'd8;

	localparam logic [OUT_BITS-1:0] SAT_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};
	localparam logic [OUT_BITS-1:0] SAT_POS = {1'b0, {(OUT_BITS-1){1'b1}}};

	// status of the value cutter as seen by the sequencer
	typedef struct packed {
		logic avail;
		logic last;
	} pfus_cut_t;

endpackage

>>> hw/rtl/packed_field_unpack_scale.sv
// channel  | direction | handshake            | payload
// config   | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// bytes    | in        | in_valid/in_ready    | data_byte, record_start
// values   | out       | out_valid/out_ready  | raw_value, scaled_value, last_of_byte
//
// each value cut from a byte passes through: cut and shift, add, sign, three 33x32
// multiply steps, round and hand-over to the output register; a byte is taken, its
// values are cut one after another, and the sequencer then finds nothing left
// reset clears the bit accumulator and loads register defaults; no clearing pass
// a stalled output holds the sequencer; the next byte is taken while the last
// value of the previous byte still waits on the output
module packed_field_unpack_scale import pfus_pkg::*; #(
	parameter int VALUE_BITS_MAX = VALUE_BITS_MAX_DEF,
	parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [BYTE_BITS-1:0]     data_byte,
	input  logic                     record_start,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [RAW_BITS-1:0]      raw_value,
	output logic [OUT_BITS-1:0]      scaled_value,
	output logic                     last_of_byte
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_CUT,
		T_RUN
	} state_t;

	state_t                    state_q;
	logic [BPV_BITS-1:0]       bpv_q;
	logic [BSCALE_BITS-1:0]    bscale_q;
	logic [REF_BITS-1:0]       ref_q;
	logic [RECIP_BITS-1:0]     recip_q;
	logic                      last_q;
	logic [RAW_BITS-1:0]       raw_q;
	logic                      out_valid_q;
	logic [RAW_BITS-1:0]       raw_out_q;
	logic [OUT_BITS-1:0]       scaled_out_q;
	logic                      last_out_q;

	logic [BPV_BITS-1:0]       width;
	logic                      in_xfer;
	logic                      take;
	logic                      out_free;
	logic                      emit;
	pfus_cut_t                 cut;
	logic [VALUE_BITS_MAX-1:0] cut_value;
	logic                      scale_done;
	logic [OUT_BITS-1:0]       scale_result;

	always_comb begin
		if (bpv_q == '0)
			width = BPV_BITS'(1);
		else if (bpv_q > BPV_BITS'(VALUE_BITS_MAX))
			width = BPV_BITS'(VALUE_BITS_MAX);
		else
			width = bpv_q;
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == T_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign take      = (state_q == T_CUT) && cut.avail;
	assign out_free  = !out_valid_q || out_ready;
	assign emit      = (state_q == T_RUN) && scale_done && out_free;

	assign out_valid    = out_valid_q;
	assign raw_value    = raw_out_q;
	assign scaled_value = scaled_out_q;
	assign last_of_byte = last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpv_q    <= BPV_RESET;
			bscale_q <= '0;
			ref_q    <= '0;
			recip_q  <= RECIP_BITS'(1) << FRAC_BITS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BITS_PER_VALUE:     bpv_q    <= cfg_data[BPV_BITS-1:0];
				REG_BINARY_SCALE:       bscale_q <= cfg_data[BSCALE_BITS-1:0];
				REG_REFERENCE_VALUE:    ref_q    <= cfg_data[REF_BITS-1:0];
				REG_DECIMAL_RECIPROCAL: recip_q  <= cfg_data[RECIP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q  <= 1'b1;
				raw_out_q    <= raw_q;
				scaled_out_q <= scale_result;
				last_out_q   <= last_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (in_xfer)
						state_q <= T_CUT;
				end
				T_CUT: begin
					if (cut.avail) begin
						last_q  <= cut.last;
						raw_q   <= RAW_BITS'(cut_value);
						state_q <= T_RUN;
					end else begin
						state_q <= T_IDLE;
					end
				end
				T_RUN: begin
					if (emit)
						state_q <= T_CUT;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	pfus_unpack #(
		.VALUE_BITS_MAX(VALUE_BITS_MAX)
	) u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (in_xfer),
		.data_byte   (data_byte),
		.record_start(record_start),
		.take        (take),
		.width       (width),
		.cut         (cut),
		.value       (cut_value)
	);

	pfus_scale #(
		.VALUE_BITS_MAX(VALUE_BITS_MAX),
		.FRAC_BITS     (FRAC_BITS)
	) u_scale (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (take),
		.value             (cut_value),
		.binary_scale      (bscale_q),
		.reference_value   (ref_q),
		.decimal_reciprocal(recip_q),
		.ack               (emit),
		.done              (scale_done),
		.result            (scale_result)
	);

endmodule

>>> hw/rtl/pfus_unpack.sv
module pfus_unpack import pfus_pkg::*; #(
	parameter int VALUE_BITS_MAX = VALUE_BITS_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [BYTE_BITS-1:0]      data_byte,
	input  logic                      record_start,
	input  logic                      take,
	input  logic [BPV_BITS-1:0]       width,
	output pfus_cut_t                 cut,
	output logic [VALUE_BITS_MAX-1:0] value
);

	logic [ACC_BITS-1:0]  acc_q;
	logic [HELD_BITS-1:0] held_q;
	logic [CNT_BITS-1:0]  cnt_q;

	logic [ACC_BITS-1:0]  acc_base;
	logic [HELD_BITS-1:0] held_base;
	logic [HELD_BITS-1:0] held_cut;
	logic [ACC_BITS-1:0]  val_mask;
	logic [ACC_BITS-1:0]  keep_mask;
	logic [ACC_BITS-1:0]  shifted;

	always_comb begin
		acc_base  = record_start ? '0 : acc_q;
		held_base = record_start ? '0 : held_q;
		held_cut  = held_q - width;
		val_mask  = (ACC_BITS'(1) << width) - ACC_BITS'(1);
		keep_mask = (ACC_BITS'(1) << held_cut) - ACC_BITS'(1);
		shifted   = (acc_q >> held_cut) & val_mask;
		value     = shifted[VALUE_BITS_MAX-1:0];
		cut.avail = (held_q >= width) && (cnt_q < CNT_BITS'(MAX_RESULTS));
		// last when no further value could be cut from this byte
		cut.last  = !((held_cut >= width) && ((cnt_q + CNT_BITS'(1)) < CNT_BITS'(MAX_RESULTS)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
			cnt_q  <= '0;
		end else if (load) begin
			acc_q  <= {acc_base[ACC_BITS-BYTE_BITS-1:0], data_byte};
			held_q <= held_base + HELD_BITS'(BYTE_BITS);
			cnt_q  <= '0;
		end else if (take) begin
			acc_q  <= acc_q & keep_mask;
			held_q <= held_cut;
			cnt_q  <= cnt_q + CNT_BITS'(1);
		end
	end

endmodule

>>> hw/rtl/pfus_scale.sv
module pfus_scale import pfus_pkg::*; #(
	parameter int VALUE_BITS_MAX = VALUE_BITS_MAX_DEF,
	parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [VALUE_BITS_MAX-1:0] value,
	input  logic [BSCALE_BITS-1:0]    binary_scale,
	input  logic [REF_BITS-1:0]       reference_value,
	input  logic [RECIP_BITS-1:0]     decimal_reciprocal,
	input  logic                      ack,
	output logic                      done,
	output logic [OUT_BITS-1:0]       result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_NEG,
		S_MUL,
		S_RND,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [STEP_BITS-1:0] step_q;
	logic [SUM_BITS-1:0]  sum_q;
	logic [MAG_BITS-1:0]  mag_q;
	logic [SUM_BITS-1:0]  prod_q;
	logic                 neg_q;
	logic [OUT_BITS-1:0]  result_q;

	logic signed [7:0]          sh;
	logic [6:0]                 sh_amt;
	logic [SUM_BITS-1:0]        x_wide;
	logic [SUM_BITS-1:0]        shifted;
	logic [SUM_BITS-1:0]        ref_wide;
	logic [SUM_BITS-1:0]        mag_full;
	logic [MAG_BITS-1:0]        mag_clamped;
	logic [LIMB_BITS:0]         mul_a;
	logic [LIMB_BITS-1:0]       carry;
	logic [2*LIMB_BITS:0]       partial;
	logic [SUM_BITS-1:0]        rounded;
	logic [SUM_BITS-1:0]        quot;
	logic                       over;
	logic [OUT_BITS-1:0]        mag_out;
	logic [OUT_BITS-1:0]        res_next;

	always_comb begin
		// E plus the fraction bits gives the shift into fixed point units
		sh       = 8'(signed'(binary_scale)) + 8'(FRAC_BITS);
		sh_amt   = sh[7] ? 7'(-sh) : sh[6:0];
		x_wide   = SUM_BITS'(value);
		shifted  = sh[7] ? (x_wide >> sh_amt) : (x_wide << sh_amt);
		ref_wide = {{(SUM_BITS-REF_BITS){reference_value[REF_BITS-1]}}, reference_value};

		mag_full    = sum_q[SUM_BITS-1] ? (~sum_q + SUM_BITS'(1)) : sum_q;
		mag_clamped = (|mag_full[SUM_BITS-1:MAG_BITS-1]) ? {1'b1, {(MAG_BITS-1){1'b0}}}
			: mag_full[MAG_BITS-1:0];

		// top limb is one bit wider than the others
		mul_a   = (step_q == STEP_BITS'(MUL_STEPS-1)) ? mag_q[LIMB_BITS:0]
			: {1'b0, mag_q[LIMB_BITS-1:0]};
		carry   = (step_q == '0) ? '0 : prod_q[SUM_BITS-1:SUM_BITS-LIMB_BITS];
		partial = (2*LIMB_BITS+1)'(mul_a * decimal_reciprocal)
			+ (2*LIMB_BITS+1)'(carry);

		rounded = prod_q + (SUM_BITS'(1) << (FRAC_BITS-1));
		quot    = rounded >> FRAC_BITS;
		if (neg_q) begin
			over    = (|quot[SUM_BITS-1:OUT_BITS]) || (quot[OUT_BITS-1:0] > SAT_NEG);
			mag_out = over ? SAT_NEG : quot[OUT_BITS-1:0];
		end else begin
			over    = |quot[SUM_BITS-1:OUT_BITS-1];
			mag_out = over ? SAT_POS : quot[OUT_BITS-1:0];
		end
		res_next = neg_q ? (~mag_out + OUT_BITS'(1)) : mag_out;
	end

	assign done   = (state_q == S_DONE);
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						sum_q   <= shifted;
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					sum_q   <= sum_q + ref_wide;
					state_q <= S_NEG;
				end
				S_NEG: begin
					neg_q   <= sum_q[SUM_BITS-1];
					mag_q   <= mag_clamped;
					step_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= {partial[2*LIMB_BITS-1:0], prod_q[SUM_BITS-LIMB_BITS-1:LIMB_BITS]};
					mag_q  <= mag_q >> LIMB_BITS;
					step_q <= step_q + STEP_BITS'(1);
					if (step_q == STEP_BITS'(MUL_STEPS-1))
						state_q <= S_RND;
				end
				S_RND: begin
					result_q <= res_next;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (ack)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> test/tb.sv
module tb;
	import pfus_pkg::*;

	localparam int FRAC          = FRAC_BITS_DEF;
	localparam int VMAX          = VALUE_BITS_MAX_DEF;
	localparam int SETTLE_CYCLES = 150;
	localparam int LONG_HOLD     = 400;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 33;

	typedef struct {
		logic [BYTE_BITS-1:0] data;
		logic                 start;
	} byte_item_t;

	typedef struct {
		logic [RAW_BITS-1:0] raw;
		logic [OUT_BITS-1:0] scaled;
		logic                last;
	} unpacked_value_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     cfg_valid    = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data     = '0;
	logic                     in_valid     = 1'b0;
	logic                     in_ready;
	logic [BYTE_BITS-1:0]     data_byte    = '0;
	logic                     record_start = 1'b0;
	logic                     out_valid;
	logic                     out_ready    = 1'b0;
	logic [RAW_BITS-1:0]      raw_value;
	logic [OUT_BITS-1:0]      scaled_value;
	logic                     last_of_byte;

	packed_field_unpack_scale u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.record_start (record_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.raw_value    (raw_value),
		.scaled_value (scaled_value),
		.last_of_byte (last_of_byte)
	);

	// predictor copy of the registers and the bit accumulator
	logic [BPV_BITS-1:0]           cur_width = BPV_RESET;
	logic signed [BSCALE_BITS-1:0] cur_scale = '0;
	logic [REF_BITS-1:0]           cur_ref   = '0;
	logic [RECIP_BITS-1:0]         cur_recip = RECIP_BITS'(1) << FRAC;
	logic [ACC_BITS-1:0]           packed_bits = '0;
	int                            bits_held   = 0;

	byte_item_t      byte_queue[$];
	unpacked_value_t expected_values[$];
	byte_item_t      next_byte;
	unpacked_value_t head_value;

	logic in_fire     = 1'b0;
	bit   idle_on     = 1'b1;
	bit   hold_active = 1'b0;
	int   src_gap     = 0;
	int   sink_gap    = 0;
	int   mismatch_count = 0;
	event long_stall_kick;

	always #1 clk = ~clk;

	function automatic logic [REF_BITS-1:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[47:0];
	endfunction

	function automatic logic [OUT_BITS-1:0] scale_sample(input logic [RAW_BITS-1:0] x);
		logic [127:0] sum;
		logic [127:0] prod;
		logic [127:0] q;
		int           sh;
		logic         neg;
		sh = int'(cur_scale) + FRAC;
		if (sh >= 0)
			sum = {96'b0, x} << sh;
		else
			sum = {96'b0, x} >> (-sh);
		sum = sum + {{80{cur_ref[REF_BITS-1]}}, cur_ref};
		neg = sum[127];
		if (neg)
			sum = -sum;
		// magnitudes at or above 2^96 units are clamped before the product
		if (sum[127:96] != '0)
			sum = 128'd1 << 96;
		prod = sum * {96'b0, cur_recip};
		q = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
		if (neg) begin
			if (q > {80'b0, SAT_NEG})
				return SAT_NEG;
			return OUT_BITS'(0) - q[OUT_BITS-1:0];
		end
		if (q > {80'b0, SAT_POS})
			return SAT_POS;
		return q[OUT_BITS-1:0];
	endfunction

	task automatic cut_byte(input logic [BYTE_BITS-1:0] b, input logic start);
		int              w;
		int              n;
		logic [ACC_BITS-1:0] x;
		unpacked_value_t v;
		w = int'(cur_width);
		if (w < 1)
			w = 1;
		if (w > VMAX)
			w = VMAX;
		if (start) begin
			packed_bits = '0;
			bits_held = 0;
		end
		packed_bits = {packed_bits[ACC_BITS-BYTE_BITS-1:0], b};
		bits_held += BYTE_BITS;
		n = 0;
		while (bits_held >= w && n < MAX_RESULTS) begin
			bits_held -= w;
			x = (packed_bits >> bits_held) & ((40'd1 << w) - 40'd1);
			packed_bits &= (40'd1 << bits_held) - 40'd1;
			v.raw = x[RAW_BITS-1:0];
			v.scaled = scale_sample(v.raw);
			v.last = (bits_held < w) || (n == MAX_RESULTS - 1);
			expected_values.push_back(v);
			n++;
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		mismatch_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_BITS_PER_VALUE:     cur_width = val[BPV_BITS-1:0];
			REG_BINARY_SCALE:       cur_scale = val[BSCALE_BITS-1:0];
			REG_REFERENCE_VALUE:    cur_ref = val[REF_BITS-1:0];
			REG_DECIMAL_RECIPROCAL: cur_recip = val[RECIP_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_byte(input logic [BYTE_BITS-1:0] b, input logic start);
		byte_item_t it;
		it.data = b;
		it.start = start;
		byte_queue.push_back(it);
	endtask

	// mostly whole records opened by record_start, the rest loose bytes
	task automatic fill_records(input int count);
		int left;
		int len;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 4) != 0) begin
				len = $urandom_range(2, 12);
				if (len > left)
					len = left;
				for (int k = 0; k < len; k++)
					push_byte(BYTE_BITS'($urandom()), k == 0);
				left -= len;
			end else begin
				push_byte(BYTE_BITS'($urandom()), 1'($urandom_range(0, 1)));
				left--;
			end
		end
	endtask

	// bytes that yield nothing may still be in flight after the last value
	task automatic settle();
		while (byte_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_values.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (src_gap > 0) begin
				src_gap = src_gap - 1;
				in_valid <= 1'b0;
			end else if (byte_queue.size() > 0) begin
				next_byte = byte_queue.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_byte.data;
				record_start <= next_byte.start;
				if (idle_on && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (sink_gap > 0) begin
			sink_gap = sink_gap - 1;
			out_ready <= 1'b0;
		end else if (hold_active) begin
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			sink_gap = $urandom_range(1, 10) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// long receiver hold-off so the input side backs up
	always begin
		@(long_stall_kick);
		@(posedge clk);
		hold_active = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_active = 1'b0;
	end

	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				cut_byte(data_byte, record_start);
			if (out_valid && out_ready) begin
				if (expected_values.size() == 0) begin
					flag_mismatch("unexpected transfer raw_value", 64'(raw_value), 64'd0);
				end else begin
					head_value = expected_values.pop_front();
					if (raw_value !== head_value.raw)
						flag_mismatch("raw_value", 64'(raw_value), 64'(head_value.raw));
					if (scaled_value !== head_value.scaled)
						flag_mismatch("scaled_value", 64'(scaled_value),
							64'(head_value.scaled));
					if (last_of_byte !== head_value.last)
						flag_mismatch("last_of_byte", 64'(last_of_byte),
							64'(head_value.last));
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [REF_BITS-1:0]    r;
		logic [BPV_BITS-1:0]    w;
		logic [BSCALE_BITS-1:0] s;
		logic [REF_BITS-1:0]    rv;
		logic [RECIP_BITS-1:0]  k;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults straight out of reset
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b0);
		settle();

		// eight values per byte at width 1
		write_reg(REG_BITS_PER_VALUE, 48'd1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h55, 1'b0);
		settle();

		// full width, largest shift and extremes of both factors: positive saturation
		write_reg(REG_BITS_PER_VALUE, 48'd32);
		write_reg(REG_BINARY_SCALE, 48'd63);
		write_reg(REG_REFERENCE_VALUE, {1'b0, {47{1'b1}}});
		write_reg(REG_DECIMAL_RECIPROCAL, 48'hFFFF_FFFF);
		push_byte(8'hFF, 1'b1);
		repeat (3) push_byte(8'hFF, 1'b0);
		repeat (4) push_byte(8'h00, 1'b0);
		settle();

		// width zero acts as one, zero reciprocal gives zero
		write_reg(REG_BITS_PER_VALUE, 48'd0);
		write_reg(REG_BINARY_SCALE, 48'h40);
		write_reg(REG_REFERENCE_VALUE, {1'b1, {47{1'b0}}});
		write_reg(REG_DECIMAL_RECIPROCAL, 48'd0);
		push_byte(8'hA5, 1'b1);
		push_byte(8'h5A, 1'b0);
		settle();

		// oversized width acts as the maximum, negative saturation
		write_reg(REG_BITS_PER_VALUE, 48'd63);
		write_reg(REG_DECIMAL_RECIPROCAL, 48'hFFFF_FFFF);
		push_byte(8'h12, 1'b1);
		push_byte(8'h34, 1'b0);
		push_byte(8'h56, 1'b0);
		push_byte(8'h78, 1'b0);
		settle();

		// writes to unused indexes leave the registers alone
		write_reg(8'd4, rand48());
		write_reg(8'hFF, rand48());
		write_reg(REG_BITS_PER_VALUE, 48'd27);
		write_reg(REG_BINARY_SCALE, 48'd0);
		write_reg(REG_REFERENCE_VALUE, 48'd0);
		write_reg(REG_DECIMAL_RECIPROCAL, 48'd65536);
		push_byte(8'hC3, 1'b1);
		push_byte(8'h3C, 1'b0);
		push_byte(8'hF0, 1'b0);
		push_byte(8'h0F, 1'b0);
		settle();

		// 24 bits left pending, then width drops to 1 and the surplus stays behind
		write_reg(REG_BITS_PER_VALUE, 48'd32);
		push_byte(8'h81, 1'b1);
		push_byte(8'h7E, 1'b0);
		push_byte(8'h99, 1'b0);
		settle();
		write_reg(REG_BITS_PER_VALUE, 48'd1);
		push_byte(8'hE7, 1'b0);
		push_byte(8'h18, 1'b0);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == PHASES - 1)
				idle_on = 1'b0;
			case ($urandom_range(0, 9))
				0: w = 6'd0;
				1: w = BPV_BITS'($urandom_range(33, 63));
				2: w = 6'd32;
				3: w = 6'd1;
				default: w = BPV_BITS'($urandom_range(1, 32));
			endcase
			if (phase == 2)
				w = 6'd1;
			if ($urandom_range(0, 3) == 0)
				s = BSCALE_BITS'($urandom());
			else
				s = BSCALE_BITS'($urandom_range(0, 40) - 20);
			r = rand48();
			case ($urandom_range(0, 4))
				0: rv = SAT_NEG;
				1: rv = SAT_POS;
				2: rv = r;
				default: rv = {{24{r[23]}}, r[23:0]};
			endcase
			case ($urandom_range(0, 5))
				0: k = '0;
				1: k = '1;
				2: k = 32'd65536;
				3: k = 32'd6554;
				4: k = 32'd655;
				default: k = $urandom();
			endcase
			r = rand48();
			write_reg(REG_BITS_PER_VALUE, {r[47:6], w});
			write_reg(REG_BINARY_SCALE, {r[47:7], s});
			write_reg(REG_REFERENCE_VALUE, rv);
			write_reg(REG_DECIMAL_RECIPROCAL, {r[47:32], k});
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_IDX_BITS'($urandom_range(4, 255)), rand48());
			fill_records(PHASE_ITEMS);
			if (phase == 2)
				-> long_stall_kick;
			settle();
		end

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
